@@ hdl/sorted_value_table_core_macros.svh @@
// Assertion macros for the sorted value table core.
// Used by sorted_value_table_core; expects clk and arst_n in scope.
`ifndef SORTED_VALUE_TABLE_CORE_MACROS_SVH
`define SORTED_VALUE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/svt_pkg.sv @@
// Package for the sorted value table core: sizes, command codes, sequencer states.
// No dependencies.
`default_nettype none

package svt_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMD_W      = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FILL,
		ST_DONE
	} seq_state_t;

endpackage

`default_nettype wire

@@ hdl/sorted_value_table_core.sv @@
// Sorted value table: an ordered multiset of signed values held in one table memory.
// Channels: a command transaction (start, command, value) is taken when start is high
// and busy is low; busy stays high until its result has been shown.
// Result: accepted, found, position, removed_count, entry_count, valid for the single
// cycle in which done is high; the receiver cannot stall and must take it then.
// One result per command. Throughput is one command at a time, set by the single read
// port of the table memory, which is walked one entry per cycle:
//   search: entries are read from index 0 up to the first match, else up to the occupancy;
//   remove: every entry read, survivors written down;
//   insert: entries above the slot are moved up from the top, then the value is written;
//   an empty table is written directly; insert into a full table and command 3 skip the table.
// Reset clears the occupancy and the sequencer; table contents need no clearing since
// only positions below the occupancy are read.
// Depends on svt_pkg, svt_ram and sorted_value_table_core_macros.svh.
`default_nettype none
`include "sorted_value_table_core_macros.svh"

module sorted_value_table_core
	import svt_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [CMD_W-1:0]             command,
	input  wire logic signed [VALUE_BITS-1:0] value,
	output logic                              done,
	output logic                              accepted,
	output logic                              found,
	output logic [IDX_W-1:0]                  position,
	output logic [CNT_W-1:0]                  removed_count,
	output logic [CNT_W-1:0]                  entry_count
);

	seq_state_t st_q, st_d;

	logic [CMD_W-1:0]      cmd_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      occ_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic [CNT_W-1:0]      keep_q;
	logic [CNT_W-1:0]      removed_q;
	logic [IDX_W-1:0]      slot_q;
	logic [IDX_W-1:0]      pos_q;
	logic                  accepted_q;
	logic                  found_q;
	logic                  dv_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [IDX_W-1:0]      raddr;
	logic [VALUE_BITS-1:0] rdata;

	logic is_ins, is_rem, is_srch;
	logic more, issue, proc, drain, take;
	logic d_ge, d_eq;
	logic ins_stop, ins_last, srch_hit;
	logic full;

	svt_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// decode
	always_comb begin
		is_ins   = (cmd_q == CMD_INSERT);
		is_rem   = (cmd_q == CMD_REMOVE);
		is_srch  = (cmd_q == CMD_SEARCH);
		full     = (occ_q == CNT_W'(CAPACITY));
		take     = start && (st_q == ST_IDLE);
		more     = is_ins ? (rd_cnt_q != '0) : (rd_cnt_q != occ_q);
		issue    = (st_q == ST_RUN) && more;
		raddr    = is_ins ? IDX_W'(rd_cnt_q - CNT_W'(1)) : rd_cnt_q[IDX_W-1:0];
		proc     = (st_q == ST_RUN) && dv_s1;
		drain    = (st_q == ST_RUN) && !more && !dv_s1;
		d_ge     = $signed(rdata) >= $signed(val_q);
		d_eq     = (rdata == val_q);
		ins_stop = proc && is_ins && !d_ge;
		ins_last = proc && is_ins && d_ge && (idx_s1 == '0);
		srch_hit = proc && is_srch && d_eq;
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_INSERT) begin
						if (full) begin
							st_d = ST_DONE;
						end else if (occ_q == '0) begin
							st_d = ST_FILL;
						end else begin
							st_d = ST_RUN;
						end
					end else if (command == CMD_REMOVE || command == CMD_SEARCH) begin
						st_d = ST_RUN;
					end else begin
						st_d = ST_DONE;
					end
				end
			end
			ST_RUN: begin
				if (ins_stop || srch_hit || drain) begin
					st_d = ST_DONE;
				end else if (ins_last) begin
					st_d = ST_FILL;
				end
			end
			ST_FILL: st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs and write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1 + IDX_W'(1);
		wdata = rdata;
		unique case (st_q)
			ST_RUN: begin
				if (proc && is_ins) begin
					we    = 1'b1;
					waddr = idx_s1 + IDX_W'(1);
					wdata = d_ge ? rdata : val_q;
				end else if (proc && is_rem && !d_eq) begin
					we    = 1'b1;
					waddr = keep_q[IDX_W-1:0];
					wdata = rdata;
				end
			end
			ST_FILL: begin
				we    = 1'b1;
				waddr = slot_q;
				wdata = val_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		busy          = (st_q != ST_IDLE);
		done          = (st_q == ST_DONE);
		accepted      = accepted_q;
		found         = found_q;
		position      = pos_q;
		removed_count = removed_q;
		entry_count   = occ_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			occ_q      <= '0;
			dv_s1      <= 1'b0;
			accepted_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			st_q  <= st_d;
			dv_s1 <= issue;
			if (take) begin
				accepted_q <= 1'b0;
				found_q    <= 1'b0;
			end
			if (ins_stop) begin
				accepted_q <= 1'b1;
				occ_q      <= occ_q + CNT_W'(1);
			end
			if (srch_hit) begin
				found_q <= 1'b1;
			end
			if (drain && is_rem) begin
				occ_q <= keep_q;
			end
			if (st_q == ST_FILL) begin
				accepted_q <= 1'b1;
				occ_q      <= occ_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
		if (take) begin
			cmd_q     <= command;
			val_q     <= value;
			rd_cnt_q  <= (command == CMD_INSERT) ? occ_q : '0;
			keep_q    <= '0;
			removed_q <= '0;
			slot_q    <= '0;
			pos_q     <= '0;
		end else begin
			if (issue) begin
				rd_cnt_q <= is_ins ? rd_cnt_q - CNT_W'(1) : rd_cnt_q + CNT_W'(1);
			end
			if (ins_stop) begin
				slot_q <= idx_s1 + IDX_W'(1);
				pos_q  <= idx_s1 + IDX_W'(1);
			end
			if (proc && is_rem) begin
				if (d_eq) begin
					removed_q <= removed_q + CNT_W'(1);
				end else begin
					keep_q <= keep_q + CNT_W'(1);
				end
			end
			if (srch_hit) begin
				pos_q <= idx_s1;
			end
			if (st_q == ST_FILL) begin
				pos_q <= slot_q;
			end
		end
	end

	`SVT_ASSERT_NOW(a_occ_range, 1'b1, occ_q <= CNT_W'(CAPACITY), "occupancy above capacity")
	`SVT_ASSERT_NEXT(a_take_busy, take, busy, "transaction taken but not held busy")
	`SVT_ASSERT_NOW(a_ins_count, done && accepted, entry_count == $past(entry_count) + CNT_W'(1), "insert count mismatch")
	`SVT_ASSERT_NOW(a_rem_count, done && is_rem, entry_count + removed_count == $past(entry_count), "remove count mismatch")
	`SVT_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result shown for more than one cycle")

endmodule

`default_nettype wire

@@ hdl/svt_ram.sv @@
// Table storage: one write port, one read port, registered read data.
// Depends on svt_pkg.
`default_nettype none

module svt_ram
	import svt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [IDX_W-1:0]      waddr,
	input  wire logic [VALUE_BITS-1:0] wdata,
	input  wire logic [IDX_W-1:0]      raddr,
	output logic      [VALUE_BITS-1:0] rdata
);

	logic [VALUE_BITS-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ verif/tb_sorted_value_table_core.sv @@
// Testbench for sorted_value_table_core: directed, table-full and random command
// sequences, each result checked against a behavioural shadow of the ordered table.
// Depends on svt_pkg and sorted_value_table_core.
`timescale 1ns / 1ps

module tb_sorted_value_table_core;
	import svt_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_LEN   = 11;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = CAPACITY + 8;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	typedef struct packed {
		logic             accepted;
		logic             found;
		logic [IDX_W-1:0] position;
		logic [CNT_W-1:0] removed_count;
		logic [CNT_W-1:0] entry_count;
	} outcome_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [CMD_W-1:0]             command;
	logic signed [VALUE_BITS-1:0] value;
	logic                         done;
	logic                         accepted;
	logic                         found;
	logic [IDX_W-1:0]             position;
	logic [CNT_W-1:0]             removed_count;
	logic [CNT_W-1:0]             entry_count;

	// shadow of the table contents, ascending
	logic signed [VALUE_BITS-1:0] sorted_vals [CAPACITY];
	int                           sorted_len;
	outcome_t                     outcome_q [$];

	int idle_pct;
	int mismatches;
	int cycle_count;
	int results_seen;
	int n_inserts, n_refused, n_removes, n_gone, n_searches, n_hits, n_unused;

	sorted_value_table_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.value         (value),
		.done          (done),
		.accepted      (accepted),
		.found         (found),
		.position      (position),
		.removed_count (removed_count),
		.entry_count   (entry_count)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic signed [VALUE_BITS-1:0] v);
		outcome_t o;
		int       slot;
		int       keep;
		int       gone;
		o = '0;
		case (cmd)
			CMD_INSERT: begin
				if (sorted_len < CAPACITY) begin
					slot = 0;
					while (slot < sorted_len && sorted_vals[slot] < v)
						slot++;
					for (int i = sorted_len; i > slot; i--)
						sorted_vals[i] = sorted_vals[i-1];
					sorted_vals[slot] = v;
					sorted_len++;
					o.accepted = 1'b1;
					o.position = IDX_W'(slot);
				end
			end
			CMD_REMOVE: begin
				keep = 0;
				gone = 0;
				for (int i = 0; i < sorted_len; i++) begin
					if (sorted_vals[i] == v)
						gone++;
					else begin
						sorted_vals[keep] = sorted_vals[i];
						keep++;
					end
				end
				sorted_len = keep;
				o.removed_count = CNT_W'(gone);
			end
			CMD_SEARCH: begin
				for (int i = 0; i < sorted_len; i++) begin
					if (sorted_vals[i] == v) begin
						o.found    = 1'b1;
						o.position = IDX_W'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		o.entry_count = CNT_W'(sorted_len);
		return o;
	endfunction

	// hits on held entries, a narrow band for duplicates, the extremes, full range
	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40 && sorted_len > 0)
			return sorted_vals[$urandom_range(sorted_len - 1)];
		if (r < 70)
			return VALUE_BITS'($urandom_range(8)) - VALUE_BITS'(4);
		if (r < 80) begin
			case ($urandom_range(3))
				0:       return VAL_MIN;
				1:       return VAL_MAX;
				2:       return VAL_MIN + 1;
				default: return VAL_MAX - 1;
			endcase
		end
		return VALUE_BITS'($urandom);
	endfunction

	task automatic send_command(input logic [CMD_W-1:0] cmd,
			input logic signed [VALUE_BITS-1:0] v);
		outcome_t o;
		start   <= 1'b1;
		command <= cmd;
		value   <= v;
		do @(posedge clk); while (busy);
		o = apply_command(cmd, v);
		outcome_q.push_back(o);
		case (cmd)
			CMD_INSERT: begin
				n_inserts++;
				if (!o.accepted) n_refused++;
			end
			CMD_REMOVE: begin
				n_removes++;
				n_gone += int'(o.removed_count);
			end
			CMD_SEARCH: begin
				n_searches++;
				if (o.found) n_hits++;
			end
			default: n_unused++;
		endcase
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with no transaction outstanding", $time);
			end else begin
				want = outcome_q.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(accepted));
				check_field("found", 32'(want.found), 32'(found));
				check_field("position", 32'(want.position), 32'(position));
				check_field("removed_count", 32'(want.removed_count), 32'(removed_count));
				check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
				results_seen++;
			end
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		send_command(CMD_SEARCH, 0);
		send_command(CMD_REMOVE, 0);
		send_command(CMD_UNUSED, 0);
		send_command(CMD_INSERT, 0);
		send_command(CMD_INSERT, VAL_MAX);
		send_command(CMD_INSERT, VAL_MIN);
		send_command(CMD_INSERT, -1);
		send_command(CMD_INSERT, 0);
		send_command(CMD_INSERT, 1);
		send_command(CMD_SEARCH, VAL_MIN);
		send_command(CMD_SEARCH, VAL_MAX);
		send_command(CMD_SEARCH, 0);
		send_command(CMD_SEARCH, 5);
		send_command(CMD_UNUSED, -1);
		send_command(CMD_REMOVE, 0);
		send_command(CMD_REMOVE, 12345);
		send_command(CMD_REMOVE, VAL_MIN);
		send_command(CMD_SEARCH, 0);
		send_command(CMD_INSERT, VAL_MAX);
		send_command(CMD_REMOVE, VAL_MAX);
		send_command(CMD_SEARCH, -1);
		send_command(CMD_SEARCH, 1);
	endtask

	task automatic test_full_table();
		logic signed [VALUE_BITS-1:0] v;
		idle_pct = 31;
		while (sorted_len < CAPACITY) begin
			if ($urandom_range(9) == 0)
				v = VALUE_BITS'($urandom);
			else
				v = VALUE_BITS'($urandom_range(20)) - VALUE_BITS'(10);
			send_command(CMD_INSERT, v);
		end
		send_command(CMD_INSERT, VAL_MIN);
		send_command(CMD_INSERT, VAL_MAX);
		send_command(CMD_INSERT, sorted_vals[CAPACITY/2]);
		send_command(CMD_SEARCH, sorted_vals[CAPACITY-1]);
		send_command(CMD_UNUSED, VAL_MAX);
		v = sorted_vals[$urandom_range(CAPACITY-1)];
		send_command(CMD_REMOVE, v);
		send_command(CMD_INSERT, v);
		send_command(CMD_INSERT, VAL_MIN);
		send_command(CMD_SEARCH, v);
	endtask

	task automatic test_random_mix(input int count, input int idle,
			input int insert_pct, input int remove_pct);
		int r;
		logic [CMD_W-1:0] cmd;
		idle_pct = idle;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < insert_pct)
				cmd = CMD_INSERT;
			else if (r < insert_pct + remove_pct)
				cmd = CMD_REMOVE;
			else if (r < 96)
				cmd = CMD_SEARCH;
			else
				cmd = CMD_UNUSED;
			send_command(cmd, pick_value());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = CMD_INSERT;
		value        = '0;
		sorted_len   = 0;
		idle_pct     = 0;
		mismatches   = 0;
		cycle_count  = 0;
		results_seen = 0;
		n_inserts    = 0;
		n_refused    = 0;
		n_removes    = 0;
		n_gone       = 0;
		n_searches   = 0;
		n_hits       = 0;
		n_unused     = 0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_random_mix(250, 0, 60, 15);
		test_random_mix(200, 70, 30, 35);
		test_random_mix(200, 31, 45, 25);
		test_random_mix(100, 0, 50, 20);

		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("summary: %0d results checked; %0d inserts (%0d refused on a full table)",
			results_seen, n_inserts, n_refused);
		$display("summary: %0d removes (%0d entries gone), %0d searches (%0d hits), %0d unused",
			n_removes, n_gone, n_searches, n_hits, n_unused);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/svt_pkg.sv
hdl/svt_ram.sv
hdl/sorted_value_table_core.sv
verif/tb_sorted_value_table_core.sv
